### rtl/integer_to_radix_ascii_top_assert.svh
// assertion macros for the radix ascii converter
// relies on i_clk and i_rst_n in the module that uses them
`ifndef INTEGER_TO_RADIX_ASCII_TOP_ASSERT_SVH
`define INTEGER_TO_RADIX_ASCII_TOP_ASSERT_SVH
`ifndef SYNTHESIS
`define I2RA_ASSERT(label, prop) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error("i2ra assertion failed");
`define I2RA_ASSERT_NEXT(label, cond, conseq) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond) |=> (conseq)) \
        else $error("i2ra assertion failed");
`else
`define I2RA_ASSERT(label, prop)
`define I2RA_ASSERT_NEXT(label, cond, conseq)
`endif
`endif

### rtl/i2ra_pkg.sv
// shared types, constants and helper functions of the radix ascii converter
// no dependencies
package i2ra_pkg;

    localparam logic [5:0] RADIX_MIN   = 6'd2;
    localparam logic [5:0] RADIX_MAX   = 6'd36;
    localparam logic [5:0] RADIX_RESET = 6'd10;
    localparam logic [6:0] MINUS_CODE  = 7'd45;
    localparam int         DIV_BITS    = 8;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIV,
        S_SIGN,
        S_READ,
        S_EMIT
    } t_back_state;

    // digit value 0..35 to '0'-'9', 'a'-'z'
    function automatic logic [6:0] digit_code(input logic [5:0] d);
        logic [6:0] c;
        if (d < 6'd10) begin
            c = {1'b0, d} + 7'd48;
        end else begin
            c = {1'b0, d} + 7'd87;
        end
        return c;
    endfunction

    // eight restoring division steps on a remainder below the radix
    // returns {quotient bits, new remainder}
    function automatic logic [13:0] div_step8(input logic [5:0] rem,
                                              input logic [7:0] bits,
                                              input logic [5:0] rad);
        logic [5:0] r;
        logic [6:0] t;
        logic [7:0] q;
        r = rem;
        q = '0;
        for (int i = DIV_BITS - 1; i >= 0; i--) begin
            t = {r, bits[i]};
            if (t >= {1'b0, rad}) begin
                q[i] = 1'b1;
                r    = 6'(t - {1'b0, rad});
            end else begin
                r    = t[5:0];
            end
        end
        return {q, r};
    endfunction

endpackage

### rtl/i2ra_front.sv
// front end: takes numbers, splits sign and magnitude, holds them in a 2-entry queue
// depends on i2ra_pkg
module i2ra_front
    import i2ra_pkg::*;
#(
    parameter int VALUE_WIDTH = 32
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    output logic                   o_ready,
    input  logic [VALUE_WIDTH-1:0] i_number,
    output logic                   o_qvalid,
    input  logic                   i_qpop,
    output logic                   o_qneg,
    output logic [VALUE_WIDTH-1:0] o_qmag
);

    logic                   r_neg [2];
    logic [VALUE_WIDTH-1:0] r_mag [2];
    logic                   r_wr_ptr, r_rd_ptr;
    logic [1:0]             r_count;
    logic                   push, pop;
    logic                   num_neg;
    logic [VALUE_WIDTH-1:0] num_mag;

    assign num_neg = i_number[VALUE_WIDTH-1];
    // the most negative value wraps to its exact unsigned magnitude
    assign num_mag = num_neg ? (~i_number + VALUE_WIDTH'(1)) : i_number;

    assign o_ready  = (r_count != 2'd2);
    assign push     = i_valid && o_ready;
    assign o_qvalid = (r_count != 2'd0);
    assign pop      = i_qpop && o_qvalid;
    assign o_qneg   = r_neg[r_rd_ptr];
    assign o_qmag   = r_mag[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            case ({push, pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_neg[r_wr_ptr] <= num_neg;
            r_mag[r_wr_ptr] <= num_mag;
        end
    end

endmodule

### rtl/i2ra_back.sv
// back end: iterative divide by the radix, digit stack, character output register
// depends on i2ra_pkg and integer_to_radix_ascii_top_assert.svh
`include "integer_to_radix_ascii_top_assert.svh"
module i2ra_back
    import i2ra_pkg::*;
#(
    parameter int VALUE_WIDTH = 32
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic [5:0]             i_radix,
    input  logic                   i_qvalid,
    output logic                   o_qpop,
    input  logic                   i_qneg,
    input  logic [VALUE_WIDTH-1:0] i_qmag,
    output logic                   o_valid,
    input  logic                   i_ready,
    output logic [6:0]             o_char,
    output logic                   o_last
);

    localparam int DW  = ((VALUE_WIDTH + DIV_BITS - 1) / DIV_BITS) * DIV_BITS;
    localparam int NCH = DW / DIV_BITS;
    localparam int CW  = (NCH > 1) ? $clog2(NCH) : 1;
    localparam int AW  = $clog2(VALUE_WIDTH);
    localparam int NW  = $clog2(VALUE_WIDTH + 1);

    t_back_state r_state, n_state;

    logic            r_neg;
    logic [DW-1:0]   r_dvd;
    logic [DW-1:0]   r_quo;
    logic [5:0]      r_rem;
    logic [CW-1:0]   r_chunk;
    logic [NW-1:0]   r_ndig;
    logic [AW-1:0]   r_idx;
    logic [5:0]      r_rd_data;
    logic [5:0]      r_stack [VALUE_WIDTH];
    logic            r_ovalid;
    logic [6:0]      r_ochar;
    logic            r_olast;

    logic [13:0]     step;
    logic [DW-1:0]   n_quo;
    logic            chunk_last;
    logic            div_done;
    logic            out_free;
    logic            out_load;
    logic [6:0]      out_char;
    logic            out_last;
    logic            start;
    logic            digit_wr;

    assign step       = div_step8(r_rem, r_dvd[DW-1 -: DIV_BITS], i_radix);
    assign n_quo      = DW'({r_quo, step[13:6]});
    assign chunk_last = (r_chunk == CW'(NCH - 1));
    // stop once the quotient is zero; the count guard keeps the stack in range
    assign div_done   = chunk_last &&
                        ((n_quo == '0) || (r_ndig == NW'(VALUE_WIDTH - 1)));
    assign out_free   = !r_ovalid || i_ready;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_qvalid) n_state = S_DIV;
            end
            S_DIV: begin
                if (div_done) n_state = r_neg ? S_SIGN : S_READ;
            end
            S_SIGN: begin
                if (out_free) n_state = S_READ;
            end
            S_READ: begin
                n_state = S_EMIT;
            end
            S_EMIT: begin
                if (out_free) n_state = (r_idx == '0) ? S_IDLE : S_READ;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // outputs of the sequencer
    always_comb begin
        start    = 1'b0;
        digit_wr = 1'b0;
        out_load = 1'b0;
        out_char = MINUS_CODE;
        out_last = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                start = i_qvalid;
            end
            S_DIV: begin
                digit_wr = chunk_last;
            end
            S_SIGN: begin
                out_load = out_free;
            end
            S_READ: begin
                out_load = 1'b0;
            end
            S_EMIT: begin
                out_load = out_free;
                out_char = digit_code(r_rd_data);
                out_last = (r_idx == '0);
            end
            default: begin
                out_load = 1'b0;
            end
        endcase
    end

    assign o_qpop = start;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (out_load) begin
                r_ovalid <= 1'b1;
            end else if (i_ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_ochar <= out_char;
            r_olast <= out_last;
        end
        if (start) begin
            r_neg   <= i_qneg;
            r_dvd   <= DW'(i_qmag);
            r_quo   <= '0;
            r_rem   <= '0;
            r_chunk <= '0;
            r_ndig  <= '0;
        end else if (r_state == S_DIV) begin
            if (chunk_last) begin
                r_ndig  <= r_ndig + NW'(1);
                r_idx   <= r_ndig[AW-1:0];
                r_dvd   <= n_quo;
                r_quo   <= '0;
                r_rem   <= '0;
                r_chunk <= '0;
            end else begin
                r_dvd   <= r_dvd << DIV_BITS;
                r_quo   <= n_quo;
                r_rem   <= step[5:0];
                r_chunk <= r_chunk + CW'(1);
            end
        end else if (r_state == S_EMIT && out_free && r_idx != '0) begin
            r_idx <= r_idx - AW'(1);
        end
    end

    // digit stack, least significant digit at the bottom
    always_ff @(posedge i_clk) begin
        if (digit_wr) begin
            r_stack[r_ndig[AW-1:0]] <= step[5:0];
        end
        r_rd_data <= r_stack[r_idx];
    end

    assign o_valid = r_ovalid;
    assign o_char  = r_ochar;
    assign o_last  = r_olast;

    `I2RA_ASSERT(a_rem_below_radix, (r_state == S_DIV) |-> (r_rem < i_radix))
    `I2RA_ASSERT(a_count_in_range, (r_state != S_IDLE) |-> (r_ndig <= NW'(VALUE_WIDTH)))
    `I2RA_ASSERT(a_emit_index_valid, (r_state == S_EMIT) |-> (NW'(r_idx) < r_ndig))
    `I2RA_ASSERT_NEXT(a_last_char_ends, (r_state == S_EMIT) && out_free && (r_idx == '0), (r_state == S_IDLE) && r_ovalid && r_olast)

endmodule

### rtl/integer_to_radix_ascii_top.sv
// each number waits in the queue, then the 8-bit-per-cycle divider forms its digits one by one
// and pushes them onto the digit stack; a minus sign goes out first if needed, then the
// characters are read from the stack and emitted, most significant digit first; the queue
// holds two numbers, and the next starts only after the last character is loaded
// reset: synchronous active low, clears the queue and sequencer, radix returns to 10
// depends on i2ra_pkg, i2ra_front and i2ra_back
module integer_to_radix_ascii_top
    import i2ra_pkg::*;
#(
    parameter int VALUE_WIDTH = 32
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  logic [5:0]                             i_cfg_data,      // radix
    input  logic                                   i_s_axis_tvalid,
    output logic                                   o_s_axis_tready,
    input  logic [((VALUE_WIDTH + 7) / 8) * 8-1:0] i_s_axis_tdata,  // number
    output logic                                   o_m_axis_tvalid,
    input  logic                                   i_m_axis_tready,
    output logic [7:0]                             o_m_axis_tdata,  // character, pad
    output logic                                   o_m_axis_tlast
);

    logic [5:0]             r_radix;
    logic [5:0]             n_radix;
    logic                   q_valid, q_pop, q_neg;
    logic [VALUE_WIDTH-1:0] q_mag;
    logic [6:0]             out_char;

    assign o_cfg_ready = 1'b1;

    // out of range writes saturate to the nearest legal base
    always_comb begin
        if (i_cfg_data < RADIX_MIN) begin
            n_radix = RADIX_MIN;
        end else if (i_cfg_data > RADIX_MAX) begin
            n_radix = RADIX_MAX;
        end else begin
            n_radix = i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radix <= RADIX_RESET;
        end else if (i_cfg_valid) begin
            r_radix <= n_radix;
        end
    end

    i2ra_front #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_s_axis_tvalid),
        .o_ready  (o_s_axis_tready),
        .i_number (i_s_axis_tdata[VALUE_WIDTH-1:0]),
        .o_qvalid (q_valid),
        .i_qpop   (q_pop),
        .o_qneg   (q_neg),
        .o_qmag   (q_mag)
    );

    i2ra_back #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_radix  (r_radix),
        .i_qvalid (q_valid),
        .o_qpop   (q_pop),
        .i_qneg   (q_neg),
        .i_qmag   (q_mag),
        .o_valid  (o_m_axis_tvalid),
        .i_ready  (i_m_axis_tready),
        .o_char   (out_char),
        .o_last   (o_m_axis_tlast)
    );

    assign o_m_axis_tdata = {1'b0, out_char};

endmodule
